// ===== hdl/path_height_smoother_top_macros.svh =====
// assertion helpers for the height smoother
`ifndef PATH_HEIGHT_SMOOTHER_TOP_MACROS_SVH
`define PATH_HEIGHT_SMOOTHER_TOP_MACROS_SVH

// same-cycle implication
`define HPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hps assertion failed");

// next-cycle implication
`define HPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hps assertion failed");

`endif

// ===== hdl/hps_pkg.sv =====
`default_nettype none

package hps_pkg;

   localparam int POS_W      = 24;
   localparam int DIF_W      = 25;
   localparam int SQ_W       = 49;
   localparam int SUM_W      = 50;
   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 25;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int WGT_W      = 17;
   localparam int MC_W       = 16;
   localparam int CMP_W      = 82;
   localparam int AVG_W      = 43;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;
   localparam int OP_W       = 4;

   localparam logic [WGT_W-1:0] WEIGHT_ONE   = 17'h10000;
   localparam logic [WGT_W-1:0] WEIGHT_RESET = 17'd9830;
   localparam logic [MC_W-1:0]  MC_RESET     = 16'd154;
   localparam logic [SUM_W-1:0] SPAN_SQ_MIN  = 50'd16384;
   // 25 * d2 >= 4096 is the same as d2 >= 164
   localparam logic [SUM_W-1:0] NEAR_SQ_MIN  = 50'd164;

   localparam logic [CSR_IDX_W-1:0] REG_Z_WEIGHT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Z_MIN_CHANGE = 1'd1;

   // multiplier schedule, one op issued per cycle
   localparam logic [OP_W-1:0] OP_SQ_DX  = 4'd0;
   localparam logic [OP_W-1:0] OP_SQ_DY  = 4'd1;
   localparam logic [OP_W-1:0] OP_SQ_DZ  = 4'd2;
   localparam logic [OP_W-1:0] OP_SQ_MC  = 4'd3;
   localparam logic [OP_W-1:0] OP_MR_LO  = 4'd4;
   localparam logic [OP_W-1:0] OP_MR_HI  = 4'd5;
   localparam logic [OP_W-1:0] OP_AVG    = 4'd6;
   localparam logic [OP_W-1:0] OP_SQ_EX  = 4'd7;
   localparam logic [OP_W-1:0] OP_SQ_EY  = 4'd8;
   localparam logic [OP_W-1:0] OP_SQ_EZ  = 4'd9;
   localparam logic [OP_W-1:0] OP_LAST   = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_MUL      = 4'b0010,
      ST_EMIT_MID = 4'b0100,
      ST_EMIT_NEW = 4'b1000
   } hps_state_type;

   typedef struct packed {
      logic       fire;
      logic [1:0] seen;
      logic       smooth;
      logic       fin;
      logic       slot_free;
   } hps_stat_type;

   typedef struct packed {
      hps_state_type   state;
      logic [OP_W-1:0] op;
   } hps_ctl_type;

   function automatic logic [DIF_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                 logic signed [POS_W-1:0] b);
      logic signed [DIF_W-1:0] d;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      return d[DIF_W-1] ? -d : d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hps_req_if.sv =====
`default_nettype none

interface hps_req_if;
   import hps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic                    final_point;

   modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

`default_nettype wire

// ===== hdl/hps_rsp_if.sv =====
`default_nettype none

interface hps_rsp_if;
   import hps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] out_x;
   logic signed [POS_W-1:0] out_y;
   logic signed [POS_W-1:0] out_z;
   logic                    out_last;

   modport source (output valid, out_x, out_y, out_z, out_last, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/hps_mul.sv =====
`default_nettype none

module hps_mul (
   input  logic                          clock,
   input  logic [hps_pkg::MUL_A_W-1:0]   mul_a,
   input  logic [hps_pkg::MUL_B_W-1:0]   mul_b,
   output logic [hps_pkg::MUL_P_W-1:0]   prod_ff
);
   import hps_pkg::*;

   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

`default_nettype wire

// ===== hdl/hps_seq.sv =====
`default_nettype none

module hps_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  hps_pkg::hps_stat_type stat,
   output hps_pkg::hps_ctl_type  ctl
);
   import hps_pkg::*;

   hps_state_type   state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            op_in = OP_SQ_DX;
            if (stat.fire) begin
               if (stat.seen == 2'd0) begin
                  state_in = ST_EMIT_NEW;
               end else if (stat.seen == 2'd1) begin
                  state_in = stat.fin ? ST_EMIT_NEW : ST_IDLE;
               end else begin
                  state_in = stat.smooth ? ST_MUL : ST_EMIT_MID;
               end
            end
         end
         ST_MUL: begin
            op_in = op_ff + 4'd1;
            if (op_ff == OP_LAST) begin
               state_in = ST_EMIT_MID;
            end
         end
         ST_EMIT_MID: begin
            if (stat.slot_free) begin
               state_in = stat.fin ? ST_EMIT_NEW : ST_IDLE;
            end
         end
         ST_EMIT_NEW: begin
            if (stat.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SQ_DX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign ctl.state = state_ff;
   assign ctl.op    = op_ff;
endmodule

`default_nettype wire

// ===== hdl/path_height_smoother_top.sv =====
// height smoother for a stream of path waypoints
//
// req_chan takes one waypoint per beat (x, y, z in signed 1/256 yard and a
// final_point mark); rsp_chan gives zero, one or two waypoints per accepted
// beat, in path order, with out_last on the last point of each path.
// csr_we/csr_index/csr_wdata write z_weight (index 0) and z_min_change
// (index 1); write them only while no point is in flight.
//
// one point at a time: req_chan.ready is high only while the block is idle.
// a path's first point goes out through the emit-new step; a second point
// that does not end the path is absorbed while the block stays idle. an
// interior point with a nonzero weight runs an eleven-step schedule on one
// shared 32x25 multiplier (span, slope, average and distance products);
// its emit step then loads the result if kept; a path end adds an emit-new
// step before the block is ready again. with zero weight an interior point
// goes straight to its emit step. a stalled rsp_chan holds the result
// register and the sequencer waits in its emit step. reset clears the
// window, restores the register defaults and leaves both channels empty.

`default_nettype none

`include "path_height_smoother_top_macros.svh"

module path_height_smoother_top (
   input  logic                             clock,
   input  logic                             reset,
   hps_req_if.sink                          req_chan,
   hps_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [hps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hps_pkg::*;

   hps_stat_type stat;
   hps_ctl_type  ctl;

   logic [WGT_W-1:0] z_weight_ff;
   logic [MC_W-1:0]  z_min_change_ff;
   logic [WGT_W-1:0] w_eff;
   logic [1:0]       seen_ff;
   logic             rsp_valid_ff;

   logic signed [POS_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic                    cur_fin_ff;
   logic signed [POS_W-1:0] older_x_ff, older_y_ff, older_z_ff;
   logic signed [POS_W-1:0] middle_x_ff, middle_y_ff, middle_z_ff;
   logic signed [POS_W-1:0] emitted_x_ff, emitted_y_ff, emitted_z_ff;
   logic signed [POS_W-1:0] running_ff, running_in;
   logic signed [POS_W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                    out_last_ff;
   logic                    smooth_ff;

   logic [SUM_W-1:0]   h2_ff;
   logic [SQ_W-1:0]    dz2_ff;
   logic [MUL_A_W-1:0] m2_ff;
   logic [MUL_P_W-1:0] rl_ff;
   logic               reset_ff;
   logic               neg_ff;
   logic [SUM_W-1:0]   d2_ff;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod_ff;
   logic [DIF_W-1:0]   sq_mag;

   logic [CMP_W-1:0]        lhs, rhs;
   logic                    span;
   logic signed [AVG_W-1:0] avg_signed, avg_round, avg_step;

   logic fire, slot_free, in_mid, in_new, keep, rsp_load;
   logic signed [POS_W-1:0] sz;

   hps_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   hps_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign w_eff      = (z_weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : z_weight_ff;
   assign req_chan.ready = (ctl.state == ST_IDLE);
   assign fire       = req_chan.valid && req_chan.ready;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign in_mid     = (ctl.state == ST_EMIT_MID) && slot_free;
   assign in_new     = (ctl.state == ST_EMIT_NEW) && slot_free;
   assign keep       = !smooth_ff || (seen_ff == 2'd2) || (d2_ff >= NEAR_SQ_MIN);
   assign sz         = smooth_ff ? running_ff : middle_z_ff;
   assign rsp_load   = (in_mid && keep) || in_new;

   assign stat.fire      = fire;
   assign stat.seen      = seen_ff;
   assign stat.smooth    = (w_eff != '0);
   assign stat.fin       = (ctl.state == ST_IDLE) ? req_chan.final_point : cur_fin_ff;
   assign stat.slot_free = slot_free;

   // operand select for the shared multiplier
   always_comb begin
      sq_mag = '0;
      case (ctl.op)
         OP_SQ_DX: sq_mag = abs_diff(cur_x_ff, older_x_ff);
         OP_SQ_DY: sq_mag = abs_diff(cur_y_ff, older_y_ff);
         OP_SQ_DZ: sq_mag = abs_diff(middle_z_ff, older_z_ff);
         OP_SQ_EX: sq_mag = abs_diff(middle_x_ff, emitted_x_ff);
         OP_SQ_EY: sq_mag = abs_diff(middle_y_ff, emitted_y_ff);
         OP_SQ_EZ: sq_mag = abs_diff(running_ff, emitted_z_ff);
         default:  sq_mag = '0;
      endcase
   end

   always_comb begin
      mul_a = MUL_A_W'(sq_mag);
      mul_b = sq_mag;
      case (ctl.op)
         OP_SQ_MC: begin
            mul_a = MUL_A_W'(z_min_change_ff);
            mul_b = MUL_B_W'(z_min_change_ff);
         end
         // zmc^2 is still in the product register here
         OP_MR_LO: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = h2_ff[MUL_B_W-1:0];
         end
         OP_MR_HI: begin
            mul_a = m2_ff;
            mul_b = h2_ff[SUM_W-1:MUL_B_W];
         end
         OP_AVG: begin
            mul_a = MUL_A_W'(w_eff);
            mul_b = abs_diff(middle_z_ff, running_ff);
         end
         default: begin
            mul_a = MUL_A_W'(sq_mag);
            mul_b = sq_mag;
         end
      endcase
   end

   // slope test: 65536 * dz^2 >= zmc^2 * h2
   assign span = (h2_ff > SPAN_SQ_MIN);
   assign lhs  = {17'b0, dz2_ff, 16'b0};
   assign rhs  = {prod_ff, 25'b0} + {25'b0, rl_ff};

   // round half up on w * (raw - running) / 65536
   assign avg_signed = neg_ff ? -{1'b0, prod_ff[AVG_W-2:0]} : {1'b0, prod_ff[AVG_W-2:0]};
   assign avg_round  = avg_signed + 43'sd32768;
   assign avg_step   = avg_round >>> 16;
   assign running_in = reset_ff ? middle_z_ff : POS_W'(running_ff + avg_step[POS_W-1:0]);

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff   <= req_chan.pos_x;
         cur_y_ff   <= req_chan.pos_y;
         cur_z_ff   <= req_chan.pos_z;
         cur_fin_ff <= req_chan.final_point;
         smooth_ff  <= (w_eff != '0);
         if (seen_ff == 2'd1 && !req_chan.final_point) begin
            middle_x_ff <= req_chan.pos_x;
            middle_y_ff <= req_chan.pos_y;
            middle_z_ff <= req_chan.pos_z;
         end
      end

      if (ctl.state == ST_MUL) begin
         case (ctl.op)
            OP_SQ_DY: h2_ff  <= prod_ff[SUM_W-1:0];
            OP_SQ_DZ: h2_ff  <= h2_ff + prod_ff[SUM_W-1:0];
            OP_SQ_MC: dz2_ff <= prod_ff[SQ_W-1:0];
            OP_MR_LO: m2_ff  <= prod_ff[MUL_A_W-1:0];
            OP_MR_HI: rl_ff  <= prod_ff;
            OP_AVG: begin
               reset_ff <= span && (lhs >= rhs);
               neg_ff   <= (middle_z_ff < running_ff);
            end
            OP_SQ_EX: running_ff <= running_in;
            OP_SQ_EY: d2_ff <= prod_ff[SUM_W-1:0];
            OP_SQ_EZ: d2_ff <= d2_ff + prod_ff[SUM_W-1:0];
            OP_LAST:  d2_ff <= d2_ff + prod_ff[SUM_W-1:0];
            default: begin
            end
         endcase
      end

      if (in_mid) begin
         if (keep) begin
            out_x_ff     <= middle_x_ff;
            out_y_ff     <= middle_y_ff;
            out_z_ff     <= sz;
            out_last_ff  <= 1'b0;
            emitted_x_ff <= middle_x_ff;
            emitted_y_ff <= middle_y_ff;
            emitted_z_ff <= sz;
         end
         if (!cur_fin_ff) begin
            older_x_ff  <= middle_x_ff;
            older_y_ff  <= middle_y_ff;
            older_z_ff  <= middle_z_ff;
            middle_x_ff <= cur_x_ff;
            middle_y_ff <= cur_y_ff;
            middle_z_ff <= cur_z_ff;
         end
      end

      if (in_new) begin
         out_x_ff    <= cur_x_ff;
         out_y_ff    <= cur_y_ff;
         out_z_ff    <= cur_z_ff;
         out_last_ff <= cur_fin_ff;
         // only a path's first point reaches here without its end mark
         if (!cur_fin_ff) begin
            older_x_ff <= cur_x_ff;
            older_y_ff <= cur_y_ff;
            older_z_ff <= cur_z_ff;
            running_ff <= cur_z_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_weight_ff     <= WEIGHT_RESET;
         z_min_change_ff <= MC_RESET;
         seen_ff         <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_Z_WEIGHT:     z_weight_ff     <= csr_wdata[WGT_W-1:0];
               REG_Z_MIN_CHANGE: z_min_change_ff <= csr_wdata[MC_W-1:0];
               default: begin
               end
            endcase
         end

         if (fire && seen_ff == 2'd1 && !req_chan.final_point) begin
            seen_ff <= 2'd2;
         end else if (in_mid && !cur_fin_ff) begin
            seen_ff <= 2'd3;
         end else if (in_new) begin
            seen_ff <= cur_fin_ff ? 2'd0 : 2'd1;
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_x    = out_x_ff;
   assign rsp_chan.out_y    = out_y_ff;
   assign rsp_chan.out_z    = out_z_ff;
   assign rsp_chan.out_last = out_last_ff;

   `HPS_ASSERT_IMP(a_reset_needs_span, clock, reset, ctl.state == ST_MUL && ctl.op == OP_SQ_EX && reset_ff, h2_ff > SPAN_SQ_MIN)
   `HPS_ASSERT_NXT(a_first_interior_kept, clock, reset, ctl.state == ST_EMIT_MID && slot_free && seen_ff == 2'd2, rsp_valid_ff)
   `HPS_ASSERT_NXT(a_busy_after_point, clock, reset, fire && seen_ff != 2'd1, !req_chan.ready)

endmodule

`default_nettype wire

// ===== bench/path_smoother_tb_pkg.sv =====
package path_smoother_tb_pkg;
   import hps_pkg::*;

   typedef logic signed [POS_W-1:0] coord_t;

   typedef struct packed {
      coord_t x;
      coord_t y;
      coord_t z;
      logic   last;
   } waypoint_t;

   function automatic longint unsigned square_mag(longint d);
      longint unsigned m;
      m = (d < 0) ? -d : d;
      return m * m;
   endfunction

   class height_scoreboard;
      coord_t           back_x, back_y, back_z;
      coord_t           mid_x, mid_y, mid_z;
      coord_t           kept_x, kept_y, kept_z;
      coord_t           avg_z;
      int               depth;
      logic [WGT_W-1:0] weight;
      logic [MC_W-1:0]  min_change;
      waypoint_t        expected_q[$];
      int               mismatches;

      function new();
         back_x = 0; back_y = 0; back_z = 0;
         mid_x = 0; mid_y = 0; mid_z = 0;
         kept_x = 0; kept_y = 0; kept_z = 0;
         avg_z = 0;
         depth = 0;
         weight = WEIGHT_RESET;
         min_change = MC_RESET;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_Z_WEIGHT)
            weight = val;
         else if (idx == REG_Z_MIN_CHANGE)
            min_change = val[MC_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void expect_point(coord_t x, coord_t y, coord_t z, logic last);
         waypoint_t p;
         p.x = x;
         p.y = y;
         p.z = z;
         p.last = last;
         expected_q = {expected_q, p};
      endfunction

      // one accepted input beat: window update and expected output beats
      function void note_point(waypoint_t p);
         logic [WGT_W-1:0] w;
         longint unsigned  span2, rise2, near2;
         bit [127:0]       lhs, rhs;
         longint           delta;
         coord_t           sz;
         bit               keep, snap;

         if (depth == 0) begin
            expect_point(p.x, p.y, p.z, p.last);
            if (!p.last) begin
               back_x = p.x; back_y = p.y; back_z = p.z;
               avg_z = p.z;
               depth = 1;
            end
            return;
         end
         if (depth == 1) begin
            if (p.last) begin
               expect_point(p.x, p.y, p.z, 1'b1);
               depth = 0;
            end else begin
               mid_x = p.x; mid_y = p.y; mid_z = p.z;
               depth = 2;
            end
            return;
         end

         w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
         sz = mid_z;
         keep = 1'b1;
         if (w != 0) begin
            span2 = square_mag(longint'(p.x) - longint'(back_x)) +
                    square_mag(longint'(p.y) - longint'(back_y));
            snap = 1'b0;
            if (span2 > SPAN_SQ_MIN) begin
               // slope test on squares: 65536 * dz^2 >= mc^2 * span^2
               rise2 = square_mag(longint'(mid_z) - longint'(back_z));
               lhs = {64'd0, rise2} << 16;
               rhs = 128'(min_change) * 128'(min_change) * 128'(span2);
               snap = (lhs >= rhs);
            end
            if (snap) begin
               avg_z = mid_z;
            end else begin
               delta = (longint'(w) * (longint'(mid_z) - longint'(avg_z)) + 32768) >>> 16;
               avg_z = coord_t'(longint'(avg_z) + delta);
            end
            sz = avg_z;
            if (depth == 3) begin
               near2 = square_mag(longint'(mid_x) - longint'(kept_x)) +
                       square_mag(longint'(mid_y) - longint'(kept_y)) +
                       square_mag(longint'(sz) - longint'(kept_z));
               keep = (25 * near2 >= 4096);
            end
         end
         if (keep) begin
            expect_point(mid_x, mid_y, sz, 1'b0);
            kept_x = mid_x; kept_y = mid_y; kept_z = sz;
         end

         if (p.last) begin
            expect_point(p.x, p.y, p.z, 1'b1);
            depth = 0;
         end else begin
            back_x = mid_x; back_y = mid_y; back_z = mid_z;
            mid_x = p.x; mid_y = p.y; mid_z = p.z;
            depth = 3;
         end
      endfunction

      task report(string msg);
         if (mismatches < 40)
            $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_result(waypoint_t got);
         waypoint_t want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected beat x=%0d y=%0d z=%0d last=%0b",
                             got.x, got.y, got.z, got.last));
            return;
         end
         want = expected_q.pop_front();
         if (got.x !== want.x)
            report($sformatf("out_x got %0d want %0d", got.x, want.x));
         if (got.y !== want.y)
            report($sformatf("out_y got %0d want %0d", got.y, want.y));
         if (got.z !== want.z)
            report($sformatf("out_z got %0d want %0d (x=%0d y=%0d)",
                             got.z, want.z, want.x, want.y));
         if (got.last !== want.last)
            report($sformatf("out_last got %0b want %0b", got.last, want.last));
      endtask
   endclass

endpackage

// ===== bench/tb_path_height_smoother_top.sv =====
module tb_path_height_smoother_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hps_pkg::*;
   import path_smoother_tb_pkg::*;

   localparam int POINT_TARGET  = 1850;
   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 3000;
   localparam int COORD_MAX     = 8388607;
   localparam int COORD_MIN     = -8388608;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hps_req_if req_chan();
   hps_rsp_if rsp_chan();

   path_height_smoother_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   height_scoreboard board = new();
   waypoint_t        in_beat, out_beat;
   int               idle_cycles = 0;
   int               points_sent = 0;
   bit               source_steady = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_cycles(bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_t nudge(coord_t v, int span);
      longint n;
      n = longint'(v) + longint'($urandom_range(2 * span)) - span;
      if (n > COORD_MAX) n = COORD_MAX;
      if (n < COORD_MIN) n = COORD_MIN;
      return coord_t'(n);
   endfunction

   function automatic int step_span();
      int r;
      r = $urandom_range(9);
      if (r < 3) return 12;
      if (r < 7) return 200;
      if (r < 9) return 2000;
      return 100000;
   endfunction

   function automatic coord_t start_coord();
      int r;
      r = $urandom_range(9);
      if (r == 0) return coord_t'($urandom());
      if (r == 1) return coord_t'(COORD_MAX - int'($urandom_range(40)));
      if (r == 2) return coord_t'(COORD_MIN + int'($urandom_range(40)));
      return coord_t'(int'($urandom_range(200000)) - 100000);
   endfunction

   task automatic send_point(input int x, input int y, input int z,
                             input logic last);
      int gap;
      gap = gap_cycles(source_steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pos_x       <= coord_t'(x);
      req_chan.pos_y       <= coord_t'(y);
      req_chan.pos_z       <= coord_t'(z);
      req_chan.final_point <= last;
      do @(posedge clock); while (!req_chan.ready);
      points_sent++;
   endtask

   // block idle: no beat outstanding and the sequencer done with dropped points
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [WGT_W-1:0] weight, input logic [MC_W-1:0] min_change);
      csr_we    <= 1'b1;
      csr_index <= REG_Z_WEIGHT;
      csr_wdata <= weight;
      @(posedge clock);
      board.set_reg(REG_Z_WEIGHT, weight);
      csr_index <= REG_Z_MIN_CHANGE;
      csr_wdata <= CSR_DATA_W'(min_change);
      @(posedge clock);
      board.set_reg(REG_Z_MIN_CHANGE, CSR_DATA_W'(min_change));
      csr_we <= 1'b0;
   endtask

   task automatic send_path();
      int     len, k, r, xy_span, z_span;
      coord_t x, y, z;
      r = $urandom_range(99);
      if (r < 5)
         len = 1;
      else if (r < 10)
         len = 2;
      else
         len = $urandom_range(3, 24);
      source_steady = ($urandom_range(4) == 0);
      x = start_coord();
      y = start_coord();
      z = start_coord();
      for (k = 0; k < len; k++) begin
         if (k > 0) begin
            if ($urandom_range(9) == 0) begin
               x = coord_t'($urandom());
               y = coord_t'($urandom());
               z = coord_t'($urandom());
            end else begin
               xy_span = step_span();
               z_span = step_span();
               x = nudge(x, xy_span);
               y = nudge(y, xy_span);
               z = nudge(z, z_span);
            end
         end
         send_point(int'(x), int'(y), int'(z), k == len - 1);
      end
   endtask

   initial begin
      logic [WGT_W-1:0] weight;
      logic [MC_W-1:0]  min_change;
      int               phase, r, phase_end;

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.pos_x       <= '0;
      req_chan.pos_y       <= '0;
      req_chan.pos_z       <= '0;
      req_chan.final_point <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one-point and two-point paths at the field extremes
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      // span exactly half a yard, a near point, then full-range jumps
      send_point(0, 0, 0, 1'b0);
      send_point(64, 0, 512, 1'b0);
      send_point(128, 0, 0, 1'b0);
      send_point(130, 0, 2, 1'b0);
      send_point(2000, 0, 5000, 1'b0);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      settle();

      // zero weight passes interior points through, close ones too
      configure('0, '0);
      send_point(0, 0, 100, 1'b0);
      send_point(10, 0, 200, 1'b0);
      send_point(11, 0, 201, 1'b0);
      send_point(12, 0, 300, 1'b1);
      settle();

      // weight above one saturates, steepest reset threshold
      configure({WGT_W{1'b1}}, {MC_W{1'b1}});
      send_point(0, 0, 0, 1'b0);
      send_point(200, 0, 1000, 1'b0);
      send_point(400, 0, -1000, 1'b0);
      send_point(600, 0, 50, 1'b0);
      send_point(601, 0, 51, 1'b1);
      settle();

      // registers change in the middle of a path
      send_point(0, 0, 0, 1'b0);
      send_point(300, 0, 300, 1'b0);
      settle();
      configure(WEIGHT_ONE, '0);
      send_point(600, 0, -300, 1'b0);
      send_point(900, 0, 900, 1'b1);
      settle();

      for (phase = 0; phase < PHASES; phase++) begin
         r = $urandom_range(9);
         case (r)
            0: weight = '0;
            1: weight = WEIGHT_ONE;
            2: weight = {WGT_W{1'b1}};
            3: weight = WGT_W'($urandom_range(65537, 131071));
            7: weight = WGT_W'($urandom_range(1, 65535));
            8: weight = WGT_W'(1);
            9: weight = WGT_W'(65535);
            default: weight = WGT_W'($urandom_range(1000, 40000));
         endcase
         r = $urandom_range(9);
         if (r == 0)
            min_change = '0;
         else if (r == 1)
            min_change = {MC_W{1'b1}};
         else if (r < 6)
            min_change = MC_W'($urandom_range(0, 600));
         else
            min_change = MC_W'($urandom_range(0, 65535));
         configure(weight, min_change);
         phase_end = points_sent + POINT_TARGET / PHASES;
         while (points_sent < phase_end)
            send_path();
         settle();
      end

      if (board.pending() != 0)
         board.report($sformatf("%0d expected waypoints never arrived", board.pending()));
      if (board.mismatches == 0)
         $display("** path_height_smoother_top: PASSED **");
      else
         $display("** path_height_smoother_top: FAILED **");
      $finish;
   end

   initial begin
      int hold;
      bit steady;
      steady = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(15) == 0)
            steady = !steady;
         hold = gap_cycles(steady);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            in_beat.x    = req_chan.pos_x;
            in_beat.y    = req_chan.pos_y;
            in_beat.z    = req_chan.pos_z;
            in_beat.last = req_chan.final_point;
            board.note_point(in_beat);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            out_beat.x    = rsp_chan.out_x;
            out_beat.y    = rsp_chan.out_y;
            out_beat.z    = rsp_chan.out_z;
            out_beat.last = rsp_chan.out_last;
            board.check_result(out_beat);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         // no beat on either channel for too long
         if (idle_cycles >= STALL_LIMIT) begin
            $display("** path_height_smoother_top: FAILED **");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hps_pkg.sv
hdl/hps_req_if.sv
hdl/hps_rsp_if.sv
hdl/hps_mul.sv
hdl/hps_seq.sv
hdl/path_height_smoother_top.sv
bench/path_smoother_tb_pkg.sv
bench/tb_path_height_smoother_top.sv
